// File: src/ordered_list_engine_assert.svh
// Assertion macros shared by the ordered list engine modules.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define OLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define OLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");

`endif

// File: src/ole_pkg.sv
// Shared types, codes and constants of the ordered list engine.
package ole_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned FIDX_W = 4;
  localparam int unsigned ECNT_W = 5;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [FIDX_W-1:0]       found_index;
    logic signed [VAL_W-1:0] removed_value;
    logic [ECNT_W-1:0]       entry_count;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic            load;      // latch request, clear capture
    logic            scan_init; // read pointer to head, all entries left
    logic            up_init;   // read pointer to tail, entries at or above position left
    logic            run;       // step the read pointer while reads remain
    logic            down;      // step direction: toward the head
    logic            wr_up;     // write read word one place higher
    logic            wr_dn;     // write read word one place lower
    logic            wr_put;    // write request value at position
    logic            cap_idx;   // report index of the read word
    logic            cap_val;   // keep the read word as removed value
    logic            cnt_inc;
    logic            cnt_dec;
    logic            resp;      // issue the result word
    logic [ST_W-1:0] status;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             ins_ok;    // position within count and list not full
    logic             up_needed; // entries sit at or above position
    logic             empty;
    logic             rvld;      // read word valid this cycle
    logic             hit;       // read word equals request value
    logic             at_last;   // read word is the last entry
    logic             at_pos;    // read word sits at the insert position
  } ctl_stat_t;

endpackage

// File: src/ole_ctrl.sv
// Request sequencer of the ordered list engine.
`include "ordered_list_engine_assert.svh"

module ole_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ole_pkg::ctl_stat_t stat,
  output ole_pkg::ctl_cmd_t  cmd
);
  import ole_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECIDE   = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SHIFT_UP = 6'b001000,
    S_SHIFT_DN = 6'b010000,
    S_PUT      = 6'b100000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.action) inside
          ACT_INSERT: begin
            if (!stat.ins_ok) begin
              cmd.resp   = 1'b1;
              cmd.status = ST_RANGE;
              state_nxt  = S_IDLE;
            end else if (stat.up_needed) begin
              cmd.up_init = 1'b1;
              state_nxt   = S_SHIFT_UP;
            end else begin
              state_nxt = S_PUT;
            end
          end
          ACT_DELETE, ACT_SEARCH: begin
            if (stat.empty) begin
              cmd.resp   = 1'b1;
              cmd.status = ST_MISS;
              state_nxt  = S_IDLE;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            cmd.resp   = 1'b1;
            cmd.status = ST_RANGE;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.run = 1'b1;
        if (stat.rvld && stat.hit) begin
          if (stat.action == ACT_SEARCH) begin
            cmd.cap_idx = 1'b1;
            cmd.resp    = 1'b1;
            cmd.status  = ST_DONE;
            state_nxt   = S_IDLE;
          end else begin
            cmd.cap_val = 1'b1;
            if (stat.at_last) begin
              cmd.cnt_dec = 1'b1;
              cmd.resp    = 1'b1;
              cmd.status  = ST_DONE;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_SHIFT_DN;
            end
          end
        end else if (stat.rvld && stat.at_last) begin
          cmd.resp   = 1'b1;
          cmd.status = ST_MISS;
          state_nxt  = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        cmd.run = 1'b1;
        if (stat.rvld) begin
          cmd.wr_dn = 1'b1;
          if (stat.at_last) begin
            cmd.cnt_dec = 1'b1;
            cmd.resp    = 1'b1;
            cmd.status  = ST_DONE;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_SHIFT_UP: begin
        cmd.run  = 1'b1;
        cmd.down = 1'b1;
        if (stat.rvld) begin
          cmd.wr_up = 1'b1;
          if (stat.at_pos) begin
            state_nxt = S_PUT;
          end
        end
      end
      S_PUT: begin
        cmd.wr_put  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.resp    = 1'b1;
        cmd.status  = ST_DONE;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `OLE_ASSERT_IMP(a_single_write, 1'b1, $onehot0({cmd.wr_up, cmd.wr_dn, cmd.wr_put}))
  `OLE_ASSERT_IMP(a_shift_needs_data, cmd.wr_up || cmd.wr_dn, stat.rvld)
  `OLE_ASSERT_NXT(a_resp_then_idle, cmd.resp, state_r == S_IDLE)

endmodule

// File: src/ole_dpath.sv
// List store, read pointer, write address, count and result register.
`include "ordered_list_engine_assert.svh"

module ole_dpath #(
  parameter int unsigned DEPTH = ole_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ole_pkg::in_word_t  in_word,
  input  ole_pkg::ctl_cmd_t  cmd,
  output ole_pkg::ctl_stat_t stat,
  output logic               out_strobe,
  output ole_pkg::out_word_t out_word
);
  import ole_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned FI_W  = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
  localparam int unsigned EC_W  = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

  logic signed [VAL_W-1:0] mem [DEPTH];

  in_word_t                req_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        left_r, left_nxt;
  logic                    rvld_r;
  logic [IDX_W-1:0]        ridx_r;
  logic signed [VAL_W-1:0] rdata_r;
  logic signed [VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic                    out_strobe_r;
  out_word_t               out_word_r, out_word_nxt;

  logic                    rd_en;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [VAL_W-1:0] wdata;
  logic [CMP_W-1:0]        pos_c, cnt_c, ridx_c;
  logic [FI_W-1:0]         fi_ext;
  logic [EC_W-1:0]         ec_ext;

  assign pos_c  = CMP_W'(req_r.position);
  assign cnt_c  = CMP_W'(count_r);
  assign ridx_c = CMP_W'(ridx_r);

  // Reads run while the pass still has entries to fetch.
  assign rd_en = cmd.run && (left_r != '0);

  always_comb begin
    ptr_nxt  = ptr_r;
    left_nxt = left_r;
    if (cmd.scan_init) begin
      ptr_nxt  = '0;
      left_nxt = count_r;
    end else if (cmd.up_init) begin
      ptr_nxt  = count_r - CNT_W'(1);
      left_nxt = CNT_W'(cnt_c - pos_c);
    end else if (rd_en) begin
      ptr_nxt  = cmd.down ? (ptr_r - CNT_W'(1)) : (ptr_r + CNT_W'(1));
      left_nxt = left_r - CNT_W'(1);
    end
  end

  always_comb begin
    we    = cmd.wr_up || cmd.wr_dn || cmd.wr_put;
    waddr = IDX_W'(req_r.position);
    wdata = req_r.value;
    if (cmd.wr_up) begin
      waddr = ridx_r + IDX_W'(1);
      wdata = rdata_r;
    end else if (cmd.wr_dn) begin
      waddr = ridx_r - IDX_W'(1);
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[ptr_r[IDX_W-1:0]];
    end
    ridx_r <= ptr_r[IDX_W-1:0];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    hit_val_nxt = hit_val_r;
    if (cmd.load) begin
      hit_val_nxt = '0;
    end else if (cmd.cap_val) begin
      hit_val_nxt = rdata_r;
    end
  end

  assign fi_ext = FI_W'(ridx_r);
  assign ec_ext = EC_W'(count_nxt);

  always_comb begin
    out_word_nxt               = out_word_r;
    out_word_nxt.status        = cmd.status;
    out_word_nxt.found_index   = cmd.cap_idx ? fi_ext[FIDX_W-1:0] : '0;
    out_word_nxt.removed_value = hit_val_nxt;
    out_word_nxt.entry_count   = ec_ext[ECNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      ptr_r        <= '0;
      left_r       <= '0;
      rvld_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      left_r       <= left_nxt;
      rvld_r       <= rd_en;
      out_strobe_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word;
    end
    hit_val_r <= hit_val_nxt;
    if (cmd.resp) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_comb begin
    stat.action    = req_r.action;
    stat.ins_ok    = (pos_c <= cnt_c) && (count_r != CNT_W'(DEPTH));
    stat.up_needed = (cnt_c > pos_c);
    stat.empty     = (count_r == '0);
    stat.rvld      = rvld_r;
    stat.hit       = (rdata_r == req_r.value);
    stat.at_last   = (ridx_c == (cnt_c - CMP_W'(1)));
    stat.at_pos    = (ridx_c == pos_c);
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `OLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `OLE_ASSERT_IMP(a_dec_nonempty, cmd.cnt_dec, count_r != '0)
  `OLE_ASSERT_NXT(a_strobe_single, out_strobe_r, !out_strobe_r)

endmodule

// File: src/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer plus list datapath.
//
//  channel  ports                      handshake
//  -------  -------------------------  ------------------------------------
//  request  start, busy, in_word       taken at an edge with start & !busy
//  result   out_strobe, out_word       one word per request, one cycle wide
//
// The time per word grows with the entries one pass walks: up to the match
// (then on to the tail for a delete), all of them on a miss, those at or above
// the insert position; an error, an empty miss and an insert at the tail walk
// none. Each pass makes at most one list read and one write a cycle.
// Synchronous rst_n empties the list; the receiver cannot stall; busy drops
// in the cycle the result word shows.
module ordered_list_engine #(
  parameter int unsigned DEPTH = ole_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ole_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output ole_pkg::out_word_t out_word
);
  import ole_pkg::*;

  // Command and status between the sequencer and the datapath.
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer: decide, walk the list, issue one result per request.
  ole_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: list store, pointers, count and the result register.
  ole_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
